// File: design/ckgb_pkg.sv
// ----------------------------------------------------------------------------
// Color keyed glyph blit: shared definitions
// Widths, command and register index codes, and the item structs that the
// blit engine and the top level exchange.
// ----------------------------------------------------------------------------
`default_nettype none

package ckgb_pkg;

   localparam int COORD_BITS      = 12;
   localparam int OFFSET_BITS     = 25;
   localparam int SCREEN_BITS     = 13;
   localparam int PITCH_BITS      = 14;
   localparam int CHAN_BITS       = 8;
   localparam int COLOR_BITS      = 3 * CHAN_BITS;
   localparam int OUT_OFFSET_BITS = 25;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 14;
   localparam int PRODUCT_BITS    = COORD_BITS + PITCH_BITS;

   localparam int REQ_FIELD_BITS  = 2 * COORD_BITS + COLOR_BITS;
   localparam int REQ_TDATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS  = OUT_OFFSET_BITS + COLOR_BITS;
   localparam int RSP_TDATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PITCH_WORDS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GLYPH_COLS    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GLYPH_ROWS    = 3'd4;

   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;
   localparam logic [PITCH_BITS-1:0]  PITCH_WORDS_RESET   = 14'd1024;
   localparam logic [COORD_BITS-1:0]  GLYPH_COLS_RESET    = 12'd64;
   localparam logic [COORD_BITS-1:0]  GLYPH_ROWS_RESET    = 12'd64;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_PIXEL = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [SCREEN_BITS-1:0] screen_width;
      logic [SCREEN_BITS-1:0] screen_height;
      logic [PITCH_BITS-1:0]  pitch_words;
      logic [COORD_BITS-1:0]  glyph_cols;
      logic [COORD_BITS-1:0]  glyph_rows;
   } cfg_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
      logic [CHAN_BITS-1:0]  src_red;
      logic [CHAN_BITS-1:0]  src_green;
      logic [CHAN_BITS-1:0]  src_blue;
   } req_item_type;

   typedef struct packed {
      logic [OUT_OFFSET_BITS-1:0] write_offset;
      logic [COLOR_BITS-1:0]      write_color;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: design/color_keyed_glyph_blit_unit.sv
// ----------------------------------------------------------------------------
// Color keyed glyph blit unit
// Turns a stream of glyph start and pixel transfers into framebuffer writes,
// dropping key-color, off-screen and out-of-glyph pixels.
// ----------------------------------------------------------------------------
// The unit takes one transfer per clock while the result register can drain,
// under any mix of start and pixel transfers. A transfer is held in the
// input register while the blit engine works on it; when the engine advances
// it updates its counters and, for a visible non-key pixel, loads the result
// register, from which the write is offered. The longest path is the
// start-offset multiply (origin row times pitch plus origin column) in the
// engine. When the result register is full and not being taken, one more
// transfer is still accepted into the input register; then the request side
// stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module color_keyed_glyph_blit_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // origin_x, origin_y, src_red, src_green, src_blue from bit 0 up
   input  wire logic [ckgb_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // cmd
   input  wire logic                                   req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // write_offset, write_color from bit 0 up, zero filled above
   output logic [ckgb_pkg::RSP_TDATA_BITS-1:0]         rsp_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [ckgb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [ckgb_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import ckgb_pkg::*;

   cfg_type      cfg_ff;
   req_item_type in_item_ff, in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type out_item_ff;
   logic         out_valid_ff, out_valid_in;

   logic         out_free;
   logic         advance;
   logic         emit;
   rsp_item_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
         cfg_ff.pitch_words   <= PITCH_WORDS_RESET;
         cfg_ff.glyph_cols    <= GLYPH_COLS_RESET;
         cfg_ff.glyph_rows    <= GLYPH_ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata[SCREEN_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata[SCREEN_BITS-1:0];
            REG_PITCH_WORDS:   cfg_ff.pitch_words   <= csr_wdata[PITCH_BITS-1:0];
            REG_GLYPH_COLS:    cfg_ff.glyph_cols    <= csr_wdata[COORD_BITS-1:0];
            REG_GLYPH_ROWS:    cfg_ff.glyph_rows    <= csr_wdata[COORD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      in_item_in.cmd       = cmd_type'(req_tuser);
      in_item_in.origin_x  = req_tdata[COORD_BITS-1:0];
      in_item_in.origin_y  = req_tdata[2*COORD_BITS-1:COORD_BITS];
      in_item_in.src_red   = req_tdata[2*COORD_BITS+CHAN_BITS-1:2*COORD_BITS];
      in_item_in.src_green = req_tdata[2*COORD_BITS+2*CHAN_BITS-1:2*COORD_BITS+CHAN_BITS];
      in_item_in.src_blue  = req_tdata[2*COORD_BITS+3*CHAN_BITS-1:2*COORD_BITS+2*CHAN_BITS];
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_free ? emit : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_item_ff <= in_item_in;
      end
      if (emit) begin
         out_item_ff <= result;
      end
   end

   ckgb_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .emit   (emit),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({out_item_ff.write_color, out_item_ff.write_offset});

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request side stalled with room in the pipeline");

   a_no_key_color_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[OUT_OFFSET_BITS+COLOR_BITS-1:OUT_OFFSET_BITS] != '0))
      else $error("key color write left the unit");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// File: design/ckgb_engine.sv
// ----------------------------------------------------------------------------
// Color keyed glyph blit: blit engine
// Holds the glyph origin, the column and row counters and the running row
// start offset, and decides for each pixel whether a framebuffer write goes out.
// ----------------------------------------------------------------------------
`default_nettype none

module ckgb_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire ckgb_pkg::req_item_type item,
   input  wire ckgb_pkg::cfg_type      cfg,
   output logic                       emit,
   output ckgb_pkg::rsp_item_type      result
);
   import ckgb_pkg::*;

   logic [COORD_BITS-1:0]   base_x_ff, base_x_in;
   logic [COORD_BITS-1:0]   base_y_ff, base_y_in;
   logic [COORD_BITS-1:0]   col_ff, col_in;
   logic [COORD_BITS-1:0]   row_ff, row_in;
   logic [OFFSET_BITS-1:0]  row_start_ff, row_start_in;
   logic                    active_ff, active_in;

   logic [COLOR_BITS-1:0]   color;
   logic [SCREEN_BITS-1:0]  target_x;
   logic [SCREEN_BITS-1:0]  target_y;
   logic                    in_glyph;
   logic                    visible;
   logic [COORD_BITS-1:0]   col_inc;
   logic [COORD_BITS-1:0]   row_inc;
   logic                    row_wrap;
   logic                    glyph_done;
   logic [PRODUCT_BITS-1:0] start_product;
   logic [PRODUCT_BITS-1:0] start_sum;
   logic [OFFSET_BITS-1:0]  pixel_offset;

   assign color    = {item.src_blue, item.src_green, item.src_red};
   assign target_x = SCREEN_BITS'(base_x_ff) + SCREEN_BITS'(col_ff);
   assign target_y = SCREEN_BITS'(base_y_ff) + SCREEN_BITS'(row_ff);
   assign in_glyph = (col_ff < cfg.glyph_cols) && (row_ff < cfg.glyph_rows);
   assign visible  = (color != '0) && (target_x < cfg.screen_width)
                     && (target_y < cfg.screen_height);

   // A counter that wraps to zero also ends its row or the glyph.
   assign col_inc    = col_ff + 1'b1;
   assign row_inc    = row_ff + 1'b1;
   assign row_wrap   = (col_inc >= cfg.glyph_cols) || (col_inc == '0);
   assign glyph_done = (row_inc >= cfg.glyph_rows) || (row_inc == '0);

   assign start_product = PRODUCT_BITS'(item.origin_y) * PRODUCT_BITS'(cfg.pitch_words);
   assign start_sum     = start_product + PRODUCT_BITS'(item.origin_x);
   assign pixel_offset  = row_start_ff + OFFSET_BITS'(col_ff);

   assign emit = go && (item.cmd == CMD_PIXEL) && active_ff && in_glyph && visible;
   assign result.write_offset = OUT_OFFSET_BITS'(pixel_offset);
   assign result.write_color  = color;

   always_comb begin
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_start_in = row_start_ff;
      active_in    = active_ff;
      case (item.cmd)
         CMD_START: begin
            base_x_in    = item.origin_x;
            base_y_in    = item.origin_y;
            col_in       = '0;
            row_in       = '0;
            row_start_in = start_sum[OFFSET_BITS-1:0];
            active_in    = 1'b1;
         end
         CMD_PIXEL: begin
            if (active_ff) begin
               if (!in_glyph) begin
                  active_in = 1'b0;
               end else if (row_wrap) begin
                  col_in       = '0;
                  row_in       = row_inc;
                  row_start_in = row_start_ff + OFFSET_BITS'(cfg.pitch_words);
                  if (glyph_done) begin
                     active_in = 1'b0;
                  end
               end else begin
                  col_in = col_inc;
               end
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         row_start_ff <= '0;
         active_ff    <= 1'b0;
      end else if (go) begin
         base_x_ff    <= base_x_in;
         base_y_ff    <= base_y_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_start_ff <= row_start_in;
         active_ff    <= active_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_needs_active: assert property (@(posedge clock) disable iff (reset)
      emit |-> active_ff && (color != '0))
      else $error("write issued outside an active glyph or with key color");

   a_start_arms_glyph: assert property (@(posedge clock) disable iff (reset)
      go && (item.cmd == CMD_START) |=> active_ff && (col_ff == '0) && (row_ff == '0))
      else $error("start transfer did not arm the glyph counters");

   a_idle_pixel_stays_idle: assert property (@(posedge clock) disable iff (reset)
      go && (item.cmd == CMD_PIXEL) && !active_ff |=> !active_ff)
      else $error("pixel transfer woke an idle engine");
`endif

endmodule

`default_nettype wire
